>>> hdl/ffp_pkg.sv
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types and constants of the first-fit tile placer.
// ----------------------------------------------------------------------------
package ffp_pkg;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 256;
    localparam int PARTS_MAX_DEF = 8;

    // Part count of one tile, wide enough for the largest part limit plus overflow.
    localparam int CNT_W = 7;
    // Holds first row plus height minus one.
    localparam int ROW_W = 6;
    localparam int WORD_BITS = 64;
    localparam int EXTENT_MAX = 511;

    typedef struct packed {
        logic [8:0] w;
        logic [4:0] h;
        logic [7:0] c;
        logic [3:0] r;
    } part_t;

    localparam int PART_W = $bits(part_t);

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_REFUSED  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_PLACE    = 2'd0,
        CMD_OVERFLOW = 2'd1,
        CMD_REFUSE   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [CNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic fail;
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PLOAD,
        B_PCHK,
        B_ORD,
        B_OCHK,
        B_EMIT
    } back_state_t;

endpackage

>>> hdl/ffp_ram.sv
// ----------------------------------------------------------------------------
// ffp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/ffp_queue.sv
// ----------------------------------------------------------------------------
// ffp_queue
// Two-entry command queue between the front and the back of the placer.
// ----------------------------------------------------------------------------
module ffp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ffp_pkg::cmd_t push_cmd,
    input  logic          pop,
    output ffp_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    ffp_pkg::cmd_t e0_reg, e0_next, e1_reg, e1_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [1:0]    wpos;

    always_comb
    begin
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        wpos     = cnt_reg - 2'(pop);
        if (pop)
        begin
            e0_next = e1_reg;
        end
        if (push)
        begin
            if (wpos == 2'd0)
            begin
                e0_next = push_cmd;
            end
            else
            begin
                e1_next = push_cmd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign head  = e0_reg;
    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);

endmodule

>>> hdl/ffp_front.sv
// ----------------------------------------------------------------------------
// ffp_front
// Accepts part requests, buffers the parts of a tile and classifies each
// finished tile into a command for the back.
// ----------------------------------------------------------------------------
module ffp_front #(
    parameter int PARTS_MAX = ffp_pkg::PARTS_MAX_DEF,
    localparam int IW = (PARTS_MAX > 1) ? $clog2(PARTS_MAX) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 stall,
    input  logic [8:0]           part_width,
    input  logic [4:0]           part_height,
    input  logic [7:0]           offset_col,
    input  logic [3:0]           offset_row,
    input  logic                 last_part,
    input  ffp_pkg::back_status_t back_st,
    input  logic                 q_full,
    output logic                 q_push,
    output ffp_pkg::cmd_t        q_cmd,
    output logic                 buf_we,
    output logic [IW-1:0]        buf_waddr,
    output ffp_pkg::part_t       buf_wdata
);

    logic [ffp_pkg::CNT_W-1:0] count_reg, count_next, cnt_new;
    logic                      halted_reg, halted_next;
    logic                      wait_reg, wait_next;
    logic                      accept;

    assign stall     = back_st.clearing || wait_reg || q_full;
    assign accept    = valid && !stall;
    assign buf_waddr = count_reg[IW-1:0];
    assign buf_wdata = '{w: part_width, h: part_height, c: offset_col, r: offset_row};

    always_comb
    begin
        count_next  = count_reg;
        halted_next = halted_reg;
        wait_next   = wait_reg;
        q_push      = 1'b0;
        q_cmd       = '{kind: ffp_pkg::CMD_REFUSE, count: '0};
        buf_we      = 1'b0;
        cnt_new     = count_reg;
        if (back_st.done)
        begin
            wait_next = 1'b0;
            if (back_st.fail)
            begin
                halted_next = 1'b1;
            end
        end
        if (accept)
        begin
            if (halted_reg)
            begin
                if (last_part)
                begin
                    count_next = '0;
                    q_push     = 1'b1;
                end
            end
            else
            begin
                if (count_reg < ffp_pkg::CNT_W'(PARTS_MAX))
                begin
                    buf_we  = 1'b1;
                    cnt_new = count_reg + 1'b1;
                end
                else
                begin
                    cnt_new = ffp_pkg::CNT_W'(PARTS_MAX + 1);
                end
                count_next = cnt_new;
                if (last_part)
                begin
                    count_next = '0;
                    q_push     = 1'b1;
                    if (cnt_new > ffp_pkg::CNT_W'(PARTS_MAX))
                    begin
                        q_cmd       = '{kind: ffp_pkg::CMD_OVERFLOW, count: cnt_new};
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        q_cmd     = '{kind: ffp_pkg::CMD_PLACE, count: cnt_new};
                        wait_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            halted_reg <= 1'b0;
            wait_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            halted_reg <= halted_next;
            wait_reg   <= wait_next;
        end
    end

endmodule

>>> hdl/ffp_back.sv
// ----------------------------------------------------------------------------
// ffp_back
// Carries out tile commands: searches the occupancy grid for the first
// fitting column, marks the cells and drives the result register.
// ----------------------------------------------------------------------------
module ffp_back #(
    parameter int GRID_ROWS = ffp_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = ffp_pkg::GRID_COLS_DEF,
    parameter int PARTS_MAX = ffp_pkg::PARTS_MAX_DEF,
    localparam int IW = (PARTS_MAX > 1) ? $clog2(PARTS_MAX) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffp_pkg::cmd_t         q_head,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic [IW-1:0]         buf_raddr,
    input  ffp_pkg::part_t        buf_rdata,
    output ffp_pkg::back_status_t back_st,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [7:0]            position_col,
    output logic [8:0]            bounding_width
);

    localparam int WORDS = (GRID_COLS + ffp_pkg::WORD_BITS - 1) / ffp_pkg::WORD_BITS;
    localparam int DEPTH = GRID_ROWS * WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int XW    = $clog2(GRID_COLS);
    localparam int SW    = ((XW > 9) ? XW : 9) + 1;
    localparam int CW    = ffp_pkg::CNT_W;
    localparam int RW    = ffp_pkg::ROW_W;

    ffp_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [XW-1:0]        x_reg, x_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [CW-1:0]        n_reg, n_next;
    logic                 mark_reg, mark_next;
    logic                 place_reg, place_next;
    ffp_pkg::status_t     stat_reg, stat_next;
    logic [RW-1:0]        row_reg, row_next, rlast_reg, rlast_next;
    logic [WW-1:0]        word_reg, word_next, first_reg, first_next;
    logic [WW-1:0]        wlast_reg, wlast_next;
    logic [5:0]           alo_reg, alo_next, ehi_reg, ehi_next;
    logic [8:0]           extent_reg, extent_next;
    logic                 ovalid_reg, ovalid_next;
    logic [1:0]           ostat_reg, ostat_next;
    logic [7:0]           opos_reg, opos_next;
    logic [8:0]           obw_reg, obw_next;

    logic                 occ_we;
    logic [AW-1:0]        occ_waddr, occ_addr;
    logic [63:0]          occ_wdata, occ_rdata, mask;
    logic [5:0]           lo, hi;
    logic [SW-1:0]        sum_a, sum_e, em1;
    logic [8:0]           right;
    logic                 row_bad, col_bad, part_last, hit, can_emit;

    ffp_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_occ (
        .clk  (clk),
        .we   (occ_we),
        .waddr(occ_waddr),
        .wdata(occ_wdata),
        .raddr(occ_addr),
        .rdata(occ_rdata)
    );

    assign buf_raddr = i_reg;
    assign occ_addr  = AW'(32'(row_reg) * 32'(WORDS) + 32'(word_reg));
    assign sum_a     = SW'(x_reg) + SW'(buf_rdata.c);
    assign sum_e     = sum_a + SW'(buf_rdata.w);
    assign em1       = sum_e - 1'b1;
    assign row_bad   = (8'(buf_rdata.r) + 8'(buf_rdata.h)) > 8'(GRID_ROWS);
    assign col_bad   = sum_e > SW'(GRID_COLS);
    assign right     = (sum_e > SW'(ffp_pkg::EXTENT_MAX)) ? 9'(ffp_pkg::EXTENT_MAX)
                                                          : sum_e[8:0];
    assign part_last = (CW'(i_reg) + 1'b1) == n_reg;
    assign lo        = (word_reg == first_reg) ? alo_reg : 6'd0;
    assign hi        = (word_reg == wlast_reg) ? ehi_reg : 6'd63;
    assign hit       = |(occ_rdata & mask);
    assign can_emit  = !ovalid_reg || !out_stall;

    always_comb
    begin
        for (int b = 0; b < 64; b++)
        begin
            mask[b] = (6'(b) >= lo) && (6'(b) <= hi);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        x_next      = x_reg;
        i_next      = i_reg;
        n_next      = n_reg;
        mark_next   = mark_reg;
        place_next  = place_reg;
        stat_next   = stat_reg;
        row_next    = row_reg;
        rlast_next  = rlast_reg;
        word_next   = word_reg;
        first_next  = first_reg;
        wlast_next  = wlast_reg;
        alo_next    = alo_reg;
        ehi_next    = ehi_reg;
        extent_next = extent_reg;
        ovalid_next = ovalid_reg && out_stall;
        ostat_next  = ostat_reg;
        opos_next   = opos_reg;
        obw_next    = obw_reg;
        occ_we      = 1'b0;
        occ_waddr   = occ_addr;
        occ_wdata   = occ_rdata | mask;
        q_pop       = 1'b0;
        back_st     = '{done: 1'b0, fail: 1'b0, clearing: 1'b0};
        unique case (state_reg)
            ffp_pkg::B_CLEAR:
            begin
                back_st.clearing = 1'b1;
                occ_we           = 1'b1;
                occ_waddr        = clr_reg;
                occ_wdata        = '0;
                clr_next         = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ffp_pkg::B_IDLE;
                end
            end
            ffp_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    n_next     = q_head.count;
                    x_next     = '0;
                    i_next     = '0;
                    mark_next  = 1'b0;
                    place_next = (q_head.kind == ffp_pkg::CMD_PLACE);
                    if (q_head.kind == ffp_pkg::CMD_PLACE)
                    begin
                        state_next = ffp_pkg::B_PLOAD;
                    end
                    else
                    begin
                        stat_next  = (q_head.kind == ffp_pkg::CMD_OVERFLOW)
                                     ? ffp_pkg::ST_OVERFLOW : ffp_pkg::ST_REFUSED;
                        state_next = ffp_pkg::B_EMIT;
                    end
                end
            end
            ffp_pkg::B_PLOAD:
            begin
                state_next = ffp_pkg::B_PCHK;
            end
            ffp_pkg::B_PCHK:
            begin
                if (row_bad || col_bad)
                begin
                    stat_next  = ffp_pkg::ST_NOFIT;
                    state_next = ffp_pkg::B_EMIT;
                end
                else
                begin
                    if (mark_reg && (right > extent_reg))
                    begin
                        extent_next = right;
                    end
                    alo_next   = sum_a[5:0];
                    ehi_next   = em1[5:0];
                    first_next = WW'(sum_a[SW-1:6]);
                    wlast_next = WW'(em1[SW-1:6]);
                    word_next  = WW'(sum_a[SW-1:6]);
                    row_next   = RW'(buf_rdata.r);
                    rlast_next = RW'(buf_rdata.r) + RW'(buf_rdata.h) - 1'b1;
                    if ((buf_rdata.h == '0) || (buf_rdata.w == '0))
                    begin
                        if (!part_last)
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = ffp_pkg::B_PLOAD;
                        end
                        else if (!mark_reg)
                        begin
                            mark_next  = 1'b1;
                            i_next     = '0;
                            state_next = ffp_pkg::B_PLOAD;
                        end
                        else
                        begin
                            stat_next  = ffp_pkg::ST_PLACED;
                            state_next = ffp_pkg::B_EMIT;
                        end
                    end
                    else
                    begin
                        state_next = ffp_pkg::B_ORD;
                    end
                end
            end
            ffp_pkg::B_ORD:
            begin
                state_next = ffp_pkg::B_OCHK;
            end
            ffp_pkg::B_OCHK:
            begin
                if (!mark_reg && hit)
                begin
                    if (x_reg == XW'(GRID_COLS - 1))
                    begin
                        stat_next  = ffp_pkg::ST_NOFIT;
                        state_next = ffp_pkg::B_EMIT;
                    end
                    else
                    begin
                        x_next     = x_reg + 1'b1;
                        i_next     = '0;
                        state_next = ffp_pkg::B_PLOAD;
                    end
                end
                else
                begin
                    occ_we = mark_reg;
                    if (word_reg != wlast_reg)
                    begin
                        word_next  = word_reg + 1'b1;
                        state_next = ffp_pkg::B_ORD;
                    end
                    else if (row_reg != rlast_reg)
                    begin
                        row_next   = row_reg + 1'b1;
                        word_next  = first_reg;
                        state_next = ffp_pkg::B_ORD;
                    end
                    else if (!part_last)
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ffp_pkg::B_PLOAD;
                    end
                    else if (!mark_reg)
                    begin
                        mark_next  = 1'b1;
                        i_next     = '0;
                        state_next = ffp_pkg::B_PLOAD;
                    end
                    else
                    begin
                        stat_next  = ffp_pkg::ST_PLACED;
                        state_next = ffp_pkg::B_EMIT;
                    end
                end
            end
            ffp_pkg::B_EMIT:
            begin
                if (can_emit)
                begin
                    ovalid_next  = 1'b1;
                    ostat_next   = stat_reg;
                    opos_next    = (stat_reg == ffp_pkg::ST_PLACED) ? 8'(x_reg) : 8'd0;
                    obw_next     = extent_reg;
                    back_st.done = place_reg;
                    back_st.fail = (stat_reg != ffp_pkg::ST_PLACED);
                    state_next   = ffp_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ffp_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ffp_pkg::B_CLEAR;
            clr_reg    <= '0;
            extent_reg <= '0;
            ovalid_reg <= 1'b0;
            place_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            extent_reg <= extent_next;
            ovalid_reg <= ovalid_next;
            place_reg  <= place_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        i_reg     <= i_next;
        n_reg     <= n_next;
        mark_reg  <= mark_next;
        stat_reg  <= stat_next;
        row_reg   <= row_next;
        rlast_reg <= rlast_next;
        word_reg  <= word_next;
        first_reg <= first_next;
        wlast_reg <= wlast_next;
        alo_reg   <= alo_next;
        ehi_reg   <= ehi_next;
        ostat_reg <= ostat_next;
        opos_reg  <= opos_next;
        obw_reg   <= obw_next;
    end

    assign out_valid      = ovalid_reg;
    assign status         = ostat_reg;
    assign position_col   = opos_reg;
    assign bounding_width = obw_reg;

endmodule

>>> hdl/first_fit_tile_placer.sv
// ----------------------------------------------------------------------------
// first_fit_tile_placer
// Places tiles made of rectangular parts at the first free column of an
// occupancy grid and reports the column and the running bounding width.
// ----------------------------------------------------------------------------
// Part requests enter on part_valid/part_stall; a request with last_part set
// closes the tile. Each closing request yields one result request on
// result_valid/result_stall; other parts yield none.
// The front takes a part whenever part_stall is low. After a closing part of a tile that
// is to be placed, it stalls until the back has emitted the result of that tile.
// The search loads each part from the part buffer (PLOAD) and checks its bounds
// (PCHK), then reads (ORD) and checks or marks (OCHK) each occupancy word it covers.
// It tries columns from 0 upward, starting again from the first part at each
// column, and after a fit makes a second pass over the parts to mark their cells.
// A refused or overflowing tile skips the search and goes straight to emit.
// After reset the occupancy memory is cleared one word per cycle, all
// GRID_ROWS * ceil(GRID_COLS / 64) words, while part_stall is high.
// Results sit in an output register; while result_stall is high the result
// holds and the back waits, and the queue lets the front go on taking parts
// until it is full, unless the front waits for the result of a placed tile.
// ----------------------------------------------------------------------------
module first_fit_tile_placer #(
    parameter int GRID_ROWS = ffp_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = ffp_pkg::GRID_COLS_DEF,
    parameter int PARTS_MAX = ffp_pkg::PARTS_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       part_valid,
    output logic       part_stall,
    input  logic [8:0] part_width,
    input  logic [4:0] part_height,
    input  logic [7:0] offset_col,
    input  logic [3:0] offset_row,
    input  logic       last_part,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] status,
    output logic [7:0] position_col,
    output logic [8:0] bounding_width
);

    localparam int IW = (PARTS_MAX > 1) ? $clog2(PARTS_MAX) : 1;

    ffp_pkg::back_status_t back_st;
    ffp_pkg::cmd_t         q_cmd, q_head;
    ffp_pkg::part_t        buf_wdata, buf_rdata;
    logic                  q_push, q_pop, q_empty, q_full, buf_we;
    logic [IW-1:0]         buf_waddr, buf_raddr;

    ffp_front #(.PARTS_MAX(PARTS_MAX)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (part_valid),
        .stall      (part_stall),
        .part_width (part_width),
        .part_height(part_height),
        .offset_col (offset_col),
        .offset_row (offset_row),
        .last_part  (last_part),
        .back_st    (back_st),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd),
        .buf_we     (buf_we),
        .buf_waddr  (buf_waddr),
        .buf_wdata  (buf_wdata)
    );

    ffp_ram #(.WIDTH(ffp_pkg::PART_W), .DEPTH(PARTS_MAX)) u_parts (
        .clk  (clk),
        .we   (buf_we),
        .waddr(buf_waddr),
        .wdata(buf_wdata),
        .raddr(buf_raddr),
        .rdata(buf_rdata)
    );

    ffp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(q_cmd),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty),
        .full    (q_full)
    );

    ffp_back #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS),
        .PARTS_MAX(PARTS_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .buf_raddr     (buf_raddr),
        .buf_rdata     (buf_rdata),
        .back_st       (back_st),
        .out_valid     (result_valid),
        .out_stall     (result_stall),
        .status        (status),
        .position_col  (position_col),
        .bounding_width(bounding_width)
    );

    // A placed position is reported only for a placed tile.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ffp_pkg::ST_PLACED)) |-> (position_col == 8'd0))
        else $error("position reported for a tile that was not placed");

    // No part request is taken while the occupancy memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_st.clearing |-> part_stall)
        else $error("part request taken during the clearing pass");

    // The command queue is never written when full and not popped.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("command queue overrun");

endmodule
